// ===== sv/ttim_pkg.sv =====
// ----------------------------------------------------------------------------
// ttim_pkg
// Shared constants and types for the tensor transpose index map unit.
// ----------------------------------------------------------------------------
package ttim_pkg;

  localparam int MAX_DIMS   = 4;
  localparam int INDEX_BITS = 32;

  localparam int DIM_W      = 16;
  localparam int PERM_W     = 2;
  localparam int SHAPE_W    = 64;
  localparam int PERM_REG_W = 8;
  localparam int CNT_W      = 3;
  localparam int POS_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam int N_W   = $clog2(MAX_DIMS + 1);
  localparam int SRC_N = 1 << PERM_W;
  localparam int DIV_W = INDEX_BITS + DIM_W;

  // hold stages that let a config write settle in the derived stride registers
  localparam int SETTLE  = MAX_DIMS + 2;
  localparam int OOR_ST  = SETTLE + 1;
  localparam int AXIS_ST = DIM_W + 2;
  localparam int LAST_ST = OOR_ST + MAX_DIMS * AXIS_ST;
  localparam int LATENCY = LAST_ST + 2;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_SHAPE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SHAPE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_PERM    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT    = CFG_IDX_W'(3);

  localparam logic [SHAPE_W-1:0]    RST_SHAPE = 64'h0001_0001_0001_0001;
  localparam logic [PERM_REG_W-1:0] RST_PERM  = 8'hE4;
  localparam logic [CNT_W-1:0]      RST_CNT   = 3'd1;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [DIM_W-1:0]      dim_t;

  typedef struct packed {
    logic oor;
    idx_t t;
    dim_t q;
    idx_t prod;
    idx_t pos;
  } item_t;

endpackage

// ===== sv/tensor_transpose_index_map_unit.sv =====
// ----------------------------------------------------------------------------
// tensor_transpose_index_map_unit
// Maps a flat output index of an N-d transpose to the flat input index.
//
//   channel | ports                                   | handshake
//   input   | start, busy, in_out_position            | start & !busy
//   result  | out_valid, out_in_position,             | out_valid, one cycle
//           | out_out_of_range                        |
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
//
// One item per cycle. After the entry register an item passes SETTLE hold
// stages, so a register write settles in the strides before the item uses
// them, then a range check stage, then per axis 16 restoring divider stages,
// a multiply and an accumulate stage, then the output register
// (6 + 1 + 72 + 1).
// Strides are re-derived by a free-running multiply chain.
// busy is high only in reset; the result side cannot stall.
// ----------------------------------------------------------------------------
module tensor_transpose_index_map_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [ttim_pkg::POS_W-1:0]      in_out_position,
  output logic                            out_valid,
  output logic [ttim_pkg::POS_W-1:0]      out_in_position,
  output logic                            out_out_of_range,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ttim_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttim_pkg::CFG_DATA_W-1:0] cfg_data
);

  // config registers
  logic [ttim_pkg::SHAPE_W-1:0]    in_shape_r;
  logic [ttim_pkg::SHAPE_W-1:0]    out_shape_r;
  logic [ttim_pkg::PERM_REG_W-1:0] perm_r;
  logic [ttim_pkg::CNT_W-1:0]      cnt_r;

  // derived strides
  logic [ttim_pkg::N_W-1:0] n_nxt;
  logic [ttim_pkg::N_W-1:0] n_r;
  ttim_pkg::dim_t           e_in_r  [ttim_pkg::MAX_DIMS];
  ttim_pkg::dim_t           e_out_r [ttim_pkg::MAX_DIMS];
  ttim_pkg::idx_t           sin_r   [ttim_pkg::MAX_DIMS];
  ttim_pkg::idx_t           sout_r  [ttim_pkg::MAX_DIMS];
  ttim_pkg::idx_t           os_r    [ttim_pkg::MAX_DIMS];
  ttim_pkg::idx_t           w_r     [ttim_pkg::MAX_DIMS];
  ttim_pkg::idx_t           istr    [ttim_pkg::SRC_N];
  ttim_pkg::idx_t           acc_r;

  // item pipeline
  logic [ttim_pkg::LAST_ST:0] vld_r;
  ttim_pkg::item_t            st_r   [ttim_pkg::LAST_ST+1];
  ttim_pkg::item_t            st_nxt [ttim_pkg::LAST_ST+1];

  logic                          out_valid_r;
  ttim_pkg::idx_t                out_pos_r;
  logic                          out_oor_r;

  assign busy      = !rst_n;
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_shape_r  <= ttim_pkg::RST_SHAPE;
      out_shape_r <= ttim_pkg::RST_SHAPE;
      perm_r      <= ttim_pkg::RST_PERM;
      cnt_r       <= ttim_pkg::RST_CNT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ttim_pkg::REG_INPUT_SHAPE:  in_shape_r  <= cfg_data;
        ttim_pkg::REG_OUTPUT_SHAPE: out_shape_r <= cfg_data;
        ttim_pkg::REG_AXIS_PERM:    perm_r      <= cfg_data[ttim_pkg::PERM_REG_W-1:0];
        ttim_pkg::REG_DIM_COUNT:    cnt_r       <= cfg_data[ttim_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cnt_r == '0) begin
      n_nxt = ttim_pkg::N_W'(1);
    end else if (cnt_r > ttim_pkg::CNT_W'(ttim_pkg::MAX_DIMS)) begin
      n_nxt = ttim_pkg::N_W'(ttim_pkg::MAX_DIMS);
    end else begin
      n_nxt = ttim_pkg::N_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    acc_r <= sout_r[0];
  end

  // suffix products over the used dims; unused dims count as 1
  for (genvar a = 0; a < ttim_pkg::MAX_DIMS; a++) begin : g_dim
    logic [ttim_pkg::DIV_W-1:0] pin;
    logic [ttim_pkg::DIV_W-1:0] pout;

    always_ff @(posedge clk) begin
      e_in_r[a]  <= (n_nxt > ttim_pkg::N_W'(a)) ?
                    in_shape_r[a*ttim_pkg::DIM_W +: ttim_pkg::DIM_W] : ttim_pkg::DIM_W'(1);
      e_out_r[a] <= (n_nxt > ttim_pkg::N_W'(a)) ?
                    out_shape_r[a*ttim_pkg::DIM_W +: ttim_pkg::DIM_W] : ttim_pkg::DIM_W'(1);
    end

    if (a == ttim_pkg::MAX_DIMS - 1) begin : g_tail
      assign pin  = ttim_pkg::DIV_W'(e_in_r[a]);
      assign pout = ttim_pkg::DIV_W'(e_out_r[a]);
      always_ff @(posedge clk) begin
        os_r[a] <= (n_r > ttim_pkg::N_W'(a)) ? ttim_pkg::INDEX_BITS'(1) : '0;
      end
      assign istr[a] = (n_r > ttim_pkg::N_W'(a)) ? ttim_pkg::INDEX_BITS'(1) : '0;
    end else begin : g_body
      assign pin  = ttim_pkg::DIV_W'(e_in_r[a]) * ttim_pkg::DIV_W'(sin_r[a+1]);
      assign pout = ttim_pkg::DIV_W'(e_out_r[a]) * ttim_pkg::DIV_W'(sout_r[a+1]);
      always_ff @(posedge clk) begin
        os_r[a] <= (n_r > ttim_pkg::N_W'(a)) ? sout_r[a+1] : '0;
      end
      assign istr[a] = (n_r > ttim_pkg::N_W'(a)) ? sin_r[a+1] : '0;
    end

    always_ff @(posedge clk) begin
      sin_r[a]  <= pin[ttim_pkg::INDEX_BITS-1:0];
      sout_r[a] <= pout[ttim_pkg::INDEX_BITS-1:0];
      w_r[a]    <= istr[perm_r[a*ttim_pkg::PERM_W +: ttim_pkg::PERM_W]];
    end
  end

  for (genvar x = ttim_pkg::MAX_DIMS; x < ttim_pkg::SRC_N; x++) begin : g_nosrc
    assign istr[x] = '0;
  end

  // entry stage
  always_comb begin
    st_nxt[0]      = '0;
    st_nxt[0].t    = in_out_position[ttim_pkg::INDEX_BITS-1:0];
  end

  for (genvar s = 1; s <= ttim_pkg::LAST_ST; s++) begin : g_st
    if (s < ttim_pkg::OOR_ST) begin : g_dly
      assign st_nxt[s] = st_r[s-1];
    end else if (s == ttim_pkg::OOR_ST) begin : g_oor
      always_comb begin
        st_nxt[s]     = st_r[s-1];
        st_nxt[s].oor = (st_r[s-1].t >= acc_r);
      end
    end else begin : g_ax
      localparam int AX   = (s - ttim_pkg::OOR_ST - 1) / ttim_pkg::AXIS_ST;
      localparam int STEP = (s - ttim_pkg::OOR_ST - 1) % ttim_pkg::AXIS_ST;
      if (STEP < ttim_pkg::DIM_W) begin : g_div
        localparam int BIT = ttim_pkg::DIM_W - 1 - STEP;
        logic [ttim_pkg::DIV_W-1:0] dv;
        logic [ttim_pkg::DIV_W-1:0] rem;
        logic [ttim_pkg::DIV_W-1:0] dif;
        assign dv  = ttim_pkg::DIV_W'(os_r[AX]) << BIT;
        assign rem = ttim_pkg::DIV_W'(st_r[s-1].t);
        assign dif = rem - dv;
        always_comb begin
          st_nxt[s] = st_r[s-1];
          if ((os_r[AX] != '0) && (rem >= dv)) begin
            st_nxt[s].t      = dif[ttim_pkg::INDEX_BITS-1:0];
            st_nxt[s].q[BIT] = 1'b1;
          end
        end
      end else if (STEP == ttim_pkg::DIM_W) begin : g_mul
        logic [ttim_pkg::DIV_W-1:0] mp;
        assign mp = ttim_pkg::DIV_W'(st_r[s-1].q) * ttim_pkg::DIV_W'(w_r[AX]);
        always_comb begin
          st_nxt[s]      = st_r[s-1];
          st_nxt[s].prod = mp[ttim_pkg::INDEX_BITS-1:0];
        end
      end else begin : g_acc
        always_comb begin
          st_nxt[s]     = st_r[s-1];
          st_nxt[s].pos = st_r[s-1].pos + st_r[s-1].prod;
          st_nxt[s].q   = '0;
        end
      end
    end
  end

  for (genvar s = 0; s <= ttim_pkg::LAST_ST; s++) begin : g_reg
    always_ff @(posedge clk) begin
      st_r[s] <= st_nxt[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[ttim_pkg::LAST_ST-1:0], start && !busy};
      out_valid_r <= vld_r[ttim_pkg::LAST_ST];
    end
  end

  always_ff @(posedge clk) begin
    out_pos_r <= st_r[ttim_pkg::LAST_ST].oor ? '0 : st_r[ttim_pkg::LAST_ST].pos;
    out_oor_r <= st_r[ttim_pkg::LAST_ST].oor;
  end

  assign out_valid        = out_valid_r;
  assign out_in_position  = ttim_pkg::POS_W'(out_pos_r);
  assign out_out_of_range = out_oor_r;

  // checks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(ttim_pkg::LATENCY) out_valid)
    else $error("item did not leave after pipeline latency");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_in_position == '0)
    else $error("out of range item carries nonzero position");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |-> acc_r != '0)
    else $error("in range item with zero element count");

endmodule

// ===== tb/ttim_checker.sv =====
// ----------------------------------------------------------------------------
// ttim_checker
// Watches the item, result and register channels of the transpose index map
// unit. Predicts the source index of every accepted item from a shadow copy
// of the registers and compares each result in order.
// ----------------------------------------------------------------------------
module ttim_checker
  import ttim_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [POS_W-1:0]      in_out_position,
  input  logic                  out_valid,
  input  logic [POS_W-1:0]      out_in_position,
  input  logic                  out_out_of_range,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  drain_done,
  output int                    fail_count,
  output int                    pending,
  output int                    checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    idx_t index;
    logic oor;
  } source_t;

  logic [SHAPE_W-1:0]    sh_in_shape;
  logic [SHAPE_W-1:0]    sh_out_shape;
  logic [PERM_REG_W-1:0] sh_perm;
  logic [CNT_W-1:0]      sh_count;

  source_t source_q[$];
  source_t want;
  bit      drain_seen;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    drain_seen = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    if (fail_count < 50) $display("MISMATCH @%0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic source_t map_to_source(input idx_t out_pos,
                                            input logic [SHAPE_W-1:0] ishape,
                                            input logic [SHAPE_W-1:0] oshape,
                                            input logic [PERM_REG_W-1:0] perm,
                                            input logic [CNT_W-1:0] cnt);
    int          n;
    int          a;
    int          src;
    idx_t        in_str[MAX_DIMS];
    idx_t        out_str[MAX_DIMS];
    idx_t        acc_i;
    idx_t        acc_o;
    idx_t        t;
    idx_t        pos;
    idx_t        os;
    idx_t        w;
    idx_t        ratio;
    source_t     r;
    n = int'(cnt);
    if (n < 1) n = 1;
    if (n > MAX_DIMS) n = MAX_DIMS;
    for (a = 0; a < MAX_DIMS; a++) begin
      in_str[a]  = '0;
      out_str[a] = '0;
    end
    acc_i = idx_t'(1);
    acc_o = idx_t'(1);
    for (a = n - 1; a >= 0; a--) begin
      in_str[a]  = acc_i;
      out_str[a] = acc_o;
      acc_i      = acc_i * idx_t'(ishape[DIM_W*a +: DIM_W]);
      acc_o      = acc_o * idx_t'(oshape[DIM_W*a +: DIM_W]);
    end
    t = out_pos;
    if (t >= acc_o) begin
      r.index = '0;
      r.oor   = 1'b1;
      return r;
    end
    pos = '0;
    for (a = 0; a < n; a++) begin
      os    = out_str[a];
      src   = int'(perm[PERM_W*a +: PERM_W]);
      w     = (src < n) ? in_str[src] : '0;
      ratio = '0;
      if (os != 0) begin
        ratio = t / os;
        t     = t - ratio * os;
      end
      pos = pos + ratio * w;
    end
    r.index = pos;
    r.oor   = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      sh_in_shape  <= RST_SHAPE;
      sh_out_shape <= RST_SHAPE;
      sh_perm      <= RST_PERM;
      sh_count     <= RST_CNT;
      source_q.delete();
    end else begin
      if (out_valid) begin
        if (source_q.size() == 0) begin
          flag_mismatch($sformatf("result %h/%b with no item pending",
                                  out_in_position, out_out_of_range));
        end else begin
          want = source_q.pop_front();
          checked++;
          if (out_in_position !== want.index)
            flag_mismatch($sformatf("in_position got %h want %h",
                                    out_in_position, want.index));
          if (out_out_of_range !== want.oor)
            flag_mismatch($sformatf("out_of_range got %b want %b",
                                    out_out_of_range, want.oor));
        end
      end
      if (start && !busy)
        source_q.push_back(map_to_source(in_out_position, sh_in_shape,
                                         sh_out_shape, sh_perm, sh_count));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INPUT_SHAPE:  sh_in_shape  <= cfg_data;
          REG_OUTPUT_SHAPE: sh_out_shape <= cfg_data;
          REG_AXIS_PERM:    sh_perm      <= cfg_data[PERM_REG_W-1:0];
          REG_DIM_COUNT:    sh_count     <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (drain_done && !drain_seen) begin
        drain_seen = 1'b1;
        if (source_q.size() != 0)
          flag_mismatch($sformatf("%0d results never arrived", source_q.size()));
      end
    end
    pending = source_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the tensor transpose index map unit. Runs a few
// directed register settings with edge indexes, then random shapes and
// permutations with mostly in-range indexes, random idle gaps on both
// channels. Checking is done by ttim_checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ttim_pkg::*;

  localparam int RAND_PHASES     = 29;
  localparam int ITEMS_PER_PHASE = 50;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [POS_W-1:0]      in_out_position;
  logic                  out_valid;
  logic [POS_W-1:0]      out_in_position;
  logic                  out_out_of_range;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  drain_done;

  int fail_count;
  int pending;
  int checked;
  int items_sent;
  int phases_run;

  logic [SHAPE_W-1:0] cur_out_shape;
  logic [CNT_W-1:0]   cur_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tensor_transpose_index_map_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_out_position  (in_out_position),
    .out_valid        (out_valid),
    .out_in_position  (out_in_position),
    .out_out_of_range (out_out_of_range),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  ttim_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_out_position  (in_out_position),
    .out_valid        (out_valid),
    .out_in_position  (out_in_position),
    .out_out_of_range (out_out_of_range),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .drain_done       (drain_done),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked)
  );

  function automatic int dims_used(input logic [CNT_W-1:0] cnt);
    if (cnt < 1) return 1;
    if (cnt > MAX_DIMS) return MAX_DIMS;
    return int'(cnt);
  endfunction

  function automatic idx_t element_total(input logic [SHAPE_W-1:0] shape,
                                         input logic [CNT_W-1:0] cnt);
    idx_t acc;
    acc = idx_t'(1);
    for (int a = 0; a < dims_used(cnt); a++)
      acc = acc * idx_t'(shape[DIM_W*a +: DIM_W]);
    return acc;
  endfunction

  function automatic dim_t rand_dim();
    int r;
    r = $urandom_range(0, 31);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 6) return dim_t'($urandom());
    return dim_t'($urandom_range(1, 8));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    int gap;
    gap = $urandom_range(0, 13);
    @(negedge clk);
    repeat (gap) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == REG_OUTPUT_SHAPE) cur_out_shape = data;
    if (idx == REG_DIM_COUNT)    cur_count     = data[CNT_W-1:0];
  endtask

  // upper data bits of the narrow registers carry noise
  task automatic set_config(input logic [SHAPE_W-1:0] ishape,
                            input logic [SHAPE_W-1:0] oshape,
                            input logic [PERM_REG_W-1:0] perm,
                            input logic [CNT_W-1:0] cnt);
    logic [CFG_DATA_W-1:0] noise;
    while (pending != 0) @(negedge clk);
    write_reg(REG_INPUT_SHAPE, ishape);
    write_reg(REG_OUTPUT_SHAPE, oshape);
    noise = {$urandom(), $urandom()};
    write_reg(REG_AXIS_PERM, {noise[CFG_DATA_W-1:PERM_REG_W], perm});
    noise = {$urandom(), $urandom()};
    write_reg(REG_DIM_COUNT, {noise[CFG_DATA_W-1:CNT_W], cnt});
    phases_run++;
  endtask

  task automatic send_item(input idx_t pos, input bit no_idle);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start           = 1'b1;
    in_out_position = pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic end_burst();
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic idx_t pick_position();
    idx_t total;
    int   r;
    total = element_total(cur_out_shape, cur_count);
    r     = $urandom_range(0, 99);
    if (total == 0 || r < 12) return idx_t'($urandom());
    if (r < 16) return total + idx_t'($urandom_range(0, 3));
    if (r < 20) return total - 1;
    if (r < 23) return '0;
    return idx_t'($urandom_range(0, total - 1));
  endfunction

  task automatic random_phase();
    int                    cnt;
    int                    n;
    int                    j;
    int                    tmp;
    int                    p[MAX_DIMS];
    dim_t                  odims[MAX_DIMS];
    dim_t                  idims[MAX_DIMS];
    logic [SHAPE_W-1:0]    ishape;
    logic [SHAPE_W-1:0]    oshape;
    logic [PERM_REG_W-1:0] perm;
    bit                    no_idle;
    cnt = $urandom_range(0, 7);
    n   = dims_used(CNT_W'(cnt));
    for (int i = 0; i < MAX_DIMS; i++) begin
      p[i]     = i;
      odims[i] = rand_dim();
      idims[i] = rand_dim();
    end
    for (int i = n - 1; i > 0; i--) begin
      j    = $urandom_range(0, i);
      tmp  = p[i];
      p[i] = p[j];
      p[j] = tmp;
    end
    for (int i = 0; i < MAX_DIMS; i++)
      perm[PERM_W*i +: PERM_W] = (i < n) ? PERM_W'(p[i]) : PERM_W'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) perm = PERM_REG_W'($urandom_range(0, 255));
    if ($urandom_range(0, 2) != 0)
      for (int i = 0; i < n; i++) idims[p[i]] = odims[i];
    for (int i = 0; i < MAX_DIMS; i++) begin
      ishape[DIM_W*i +: DIM_W] = idims[i];
      oshape[DIM_W*i +: DIM_W] = odims[i];
    end
    set_config(ishape, oshape, perm, CNT_W'(cnt));
    no_idle = ($urandom_range(0, 3) == 0);
    repeat (ITEMS_PER_PHASE) send_item(pick_position(), no_idle);
    end_burst();
  endtask

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int waited;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_out_position = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    drain_done      = 1'b0;
    items_sent      = 0;
    phases_run      = 0;
    cur_out_shape   = RST_SHAPE;
    cur_count       = RST_CNT;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // reset registers: one element
    send_item('0, 1'b0);
    send_item(idx_t'(1), 1'b1);
    send_item('1, 1'b1);
    end_burst();

    // 2x3x4x5 reversed to 5x4x3x2
    set_config(64'h0005_0004_0003_0002, 64'h0002_0003_0004_0005, 8'h1B, 3'd4);
    send_item('0, 1'b1);
    send_item(idx_t'(1), 1'b1);
    send_item(idx_t'(119), 1'b0);
    send_item(idx_t'(120), 1'b1);
    send_item('1, 1'b1);
    send_item(idx_t'(32'h7FFF_FFFF), 1'b0);
    send_item(idx_t'(59), 1'b1);
    end_burst();

    // count of zero acts as one, all-ones registers
    set_config('1, '1, '1, 3'd0);
    send_item('0, 1'b1);
    send_item(idx_t'(16'hFFFE), 1'b1);
    send_item(idx_t'(16'hFFFF), 1'b1);
    end_burst();

    // count above four acts as four; element total wraps to zero
    set_config(64'h0001_0004_8000_8000, 64'h0001_0004_8000_8000, 8'hE4, 3'd7);
    send_item('0, 1'b1);
    send_item(idx_t'(5), 1'b0);
    end_burst();

    // zero output dimension, zero input shape
    set_config('0, 64'h0007_0005_0000_0003, 8'h4E, 3'd4);
    send_item('0, 1'b1);
    send_item(idx_t'(1), 1'b1);
    end_burst();

    // permutation names axes beyond the count
    set_config(64'h0000_0000_0006_0007, 64'h0000_0000_0007_0006, 8'hFF, 3'd2);
    send_item('0, 1'b1);
    send_item(idx_t'(41), 1'b1);
    send_item(idx_t'(13), 1'b0);
    end_burst();

    repeat (RAND_PHASES) random_phase();

    waited = 0;
    while (pending != 0 && waited < 4 * LATENCY) begin
      @(negedge clk);
      waited++;
    end
    repeat (LATENCY) @(negedge clk);
    drain_done = 1'b1;
    repeat (2) @(negedge clk);

    $display("Covered %0d items over %0d register settings, %0d results compared.",
             items_sent, phases_run, checked);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
